### src/les_pkg.sv
// Package for the loop event sequencer: widths, constants and shared types.
// No dependencies.
package les_pkg;
   localparam int PosW = 16;
   localparam int NoteW = 3;
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [PosW-1:0] TICKS_PER_STEP = 16'd24;
   localparam logic [PosW-1:0] SHORT_LEN = 16'd4;
   localparam logic [2:0] CSR_LOOP_STEPS = 3'd0;

   typedef struct packed {
      logic [PosW-1:0]  start;
      logic [PosW-1:0]  stop;
      logic [NoteW-1:0] note;
      logic             playing;
   } entry_type;

   // per-cycle command for one cell; each cell gets its own
   typedef struct packed {
      logic            shift;    // take left neighbor's entry
      logic            pull;     // take right neighbor's entry
      logic            load;     // write new entry here
      logic            trim;     // set stop to trim value
      logic            clr_play;
      logic            set_play;
   } cell_ctl_type;
endpackage

### src/les_cell.sv
// One slot of the event table: holds an entry and hands it along the row.
// Depends on les_pkg.
module les_cell (
   input  logic                 clock,
   input  les_pkg::cell_ctl_type ctl,
   input  les_pkg::entry_type   left_in,
   input  les_pkg::entry_type   right_in,
   input  les_pkg::entry_type   new_in,
   input  logic [les_pkg::PosW-1:0] trim_val,
   input  logic                 reset,
   output les_pkg::entry_type   entry_out
);
   les_pkg::entry_type entry_ff, entry_in;
   logic play_ff, play_in;

   always_comb begin
      entry_in = entry_ff;
      play_in = play_ff;
      if (ctl.load) begin
         entry_in = new_in;
         play_in = 1'b0;
      end else if (ctl.shift) begin
         entry_in = left_in;
         play_in = left_in.playing;
      end else if (ctl.pull) begin
         entry_in = right_in;
         play_in = right_in.playing;
      end else begin
         if (ctl.trim) entry_in.stop = trim_val;
         if (ctl.clr_play) play_in = 1'b0;
         if (ctl.set_play) play_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) play_ff <= 1'b0;
      else play_ff <= play_in;
   end

   always_comb begin
      entry_out = entry_ff;
      entry_out.playing = play_ff;
   end
endmodule

### src/loop_event_sequencer_top.sv
// Loop event sequencer top level: request decode, sequencer and a row of table cells.
// Depends on les_pkg and les_cell.
//
// A tick beat passes through S_TICK and S_OUT; a begin beat, an unknown request
// or a dropped finish goes straight to S_OUT. A finish that inserts
// runs a sequencer that walks the row of cells one slot a cycle: a scan pass
// over all MAX_EVENTS slots to trim and find the insert point and the run of
// overlapped events, then S_DEL pulls slots left for each removed event beyond
// the first, and S_OPEN shifts them right when none is removed, to close or
// open the gap; S_LOAD loads the entry and S_OUT presents the result.
// Each cell takes a neighbor's entry on a shift or a pull. One beat is worked
// at a time; req_stall stays high while a beat is worked and while a result
// waits in the output register under rsp_stall.
module loop_event_sequencer_top #(
   parameter int MAX_EVENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [10:0] req_position,
   input  logic [2:0]  req_note,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_note_on,
   output logic        rsp_note_off,
   output logic [2:0]  rsp_note_out,
   output logic        rsp_dropped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CW = $clog2(MAX_EVENTS + 1);
   localparam int PW = les_pkg::PosW;
   localparam logic [2:0] CSR_IDX = les_pkg::CSR_LOOP_STEPS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_TICK  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_DEL   = 7'b0001000,
      S_OPEN  = 7'b0010000,
      S_LOAD  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] steps_ff, steps_in;
   logic [PW-1:0] lend;

   // request hold
   logic [10:0] rpos_ff;
   logic [PW-1:0] pstart_ff, pstart_in;
   logic [2:0] pnote_ff, pnote_in;
   logic pvalid_ff, pvalid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] q_ff, q_in;
   // scan results
   logic [CW-1:0] scan_ff, scan_in, k_ff, k_in, r_ff, r_in, sh_ff, sh_in;
   logic kfound_ff, kfound_in, rdone_ff, rdone_in, tlast_ff, tlast_in;
   logic [PW-1:0] e_ff, e_in;
   // result
   logic on_ff, on_in, off_ff, off_in, drop_ff, drop_in, rv_ff, rv_in;
   logic [2:0] nout_ff, nout_in;

   les_pkg::entry_type ent [MAX_EVENTS];
   les_pkg::entry_type lft [MAX_EVENTS];
   les_pkg::entry_type rgt [MAX_EVENTS];
   les_pkg::cell_ctl_type ctl [MAX_EVENTS];
   les_pkg::entry_type new_ent;
   les_pkg::entry_type scan_ent, q_ent;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_IDX) ? {25'd0, steps_ff} : 32'd0;

   always_comb begin
      steps_in = steps_ff;
      if (psel && penable && pwrite && paddr == CSR_IDX) steps_in = pwdata[6:0];
   end
   assign lend = ((steps_ff == 7'd0) ? 16'd1 : {9'd0, steps_ff})
                 * les_pkg::TICKS_PER_STEP - 16'd1;

   assign scan_ent = ent[scan_ff[IW-1:0]];
   assign q_ent = ent[q_ff];

   genvar g;
   generate
      for (g = 0; g < MAX_EVENTS; g++) begin : g_row
         if (g == 0) begin : g_first
            assign lft[g] = ent[g];
         end else begin : g_next
            assign lft[g] = ent[g-1];
         end
         if (g == MAX_EVENTS - 1) begin : g_last
            assign rgt[g] = ent[g];
         end else begin : g_prev
            assign rgt[g] = ent[g+1];
         end
         les_cell u_cell (
            .clock(clock), .ctl(ctl[g]), .left_in(lft[g]), .right_in(rgt[g]),
            .new_in(new_ent), .trim_val(pstart_ff - 16'd1), .reset(reset),
            .entry_out(ent[g])
         );
      end
   endgenerate

   always_comb begin
      new_ent.start = pstart_ff;
      new_ent.stop = e_ff;
      new_ent.note = pnote_ff;
      new_ent.playing = 1'b0;
   end

   // cell commands; removal pulls the slots right of k one place left per
   // cycle, once for each removed event beyond the first
   always_comb begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
         ctl[i] = '0;
         if (state_ff == S_SCAN && scan_ff[IW-1:0] == IW'(i) && !kfound_ff
             && scan_ff < count_ff && scan_ent.start < pstart_ff
             && scan_ent.stop >= pstart_ff)
            ctl[i].trim = 1'b1;
         if (state_ff == S_OPEN && CW'(i) > k_ff && CW'(i) <= count_ff)
            ctl[i].shift = 1'b1;
         if (state_ff == S_DEL && r_ff != '0 && sh_ff + 1'b1 < r_ff
             && CW'(i) > k_ff && CW'(i + 1) < count_ff)
            ctl[i].pull = 1'b1;
         if (state_ff == S_LOAD && CW'(i) == k_ff)
            ctl[i].load = 1'b1;
         if (state_ff == S_TICK && q_ff == IW'(i) && count_ff != '0) begin
            if (!q_ent.playing && {5'd0, rpos_ff} == q_ent.start)
               ctl[i].set_play = 1'b1;
            else if (q_ent.playing && {5'd0, rpos_ff} == q_ent.stop)
               ctl[i].clr_play = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff; scan_in = scan_ff; k_in = k_ff; r_in = r_ff;
      sh_in = sh_ff; kfound_in = kfound_ff; rdone_in = rdone_ff;
      tlast_in = tlast_ff; e_in = e_ff; count_in = count_ff; q_in = q_ff;
      pstart_in = pstart_ff; pnote_in = pnote_ff; pvalid_in = pvalid_ff;
      on_in = on_ff; off_in = off_ff; drop_in = drop_ff; nout_in = nout_ff;
      rv_in = rv_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               on_in = 1'b0; off_in = 1'b0; drop_in = 1'b0; nout_in = '0;
               unique case (req_type)
                  les_pkg::REQ_TICK: state_in = S_TICK;
                  les_pkg::REQ_BEGIN: begin
                     pstart_in = {5'd0, req_position}; pnote_in = req_note;
                     pvalid_in = 1'b1; state_in = S_OUT;
                  end
                  les_pkg::REQ_FINISH: begin
                     pvalid_in = 1'b0;
                     if (!pvalid_ff || count_ff >= CW'(MAX_EVENTS)) begin
                        drop_in = 1'b1; state_in = S_OUT;
                     end else begin
                        if ({5'd0, req_position} < pstart_ff) e_in = lend;
                        else if ({5'd0, req_position} == pstart_ff)
                           e_in = (pstart_ff + les_pkg::SHORT_LEN > lend) ? lend
                                  : pstart_ff + les_pkg::SHORT_LEN;
                        else e_in = {5'd0, req_position};
                        scan_in = '0; k_in = count_ff; r_in = '0;
                        kfound_in = 1'b0; rdone_in = 1'b0; tlast_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_TICK: begin
            if (count_ff != '0) begin
               if (!q_ent.playing) begin
                  if ({5'd0, rpos_ff} == q_ent.start) begin
                     on_in = 1'b1; nout_in = q_ent.note;
                  end
               end else if ({5'd0, rpos_ff} == q_ent.stop) begin
                  off_in = 1'b1; nout_in = q_ent.note;
                  q_in = ({1'b0, q_ff} + 1'b1 < {1'b0, count_ff}) ? q_ff + 1'b1 : '0;
               end
            end
            state_in = S_OUT;
         end
         S_SCAN: begin
            if (scan_ff < count_ff) begin
               if (!kfound_ff) begin
                  if (scan_ent.start < pstart_ff) begin
                     if (scan_ent.stop >= pstart_ff && scan_ff + 1'b1 == count_ff)
                        tlast_in = 1'b1;
                  end else begin
                     kfound_in = 1'b1; k_in = scan_ff;
                     if (scan_ent.start <= e_ff) r_in = CW'(1);
                     else rdone_in = 1'b1;
                  end
               end else if (!rdone_ff) begin
                  if (scan_ent.start <= e_ff) r_in = r_ff + 1'b1;
                  else rdone_in = 1'b1;
               end
            end
            if (scan_ff == CW'(MAX_EVENTS - 1)) begin
               sh_in = '0;
               state_in = S_DEL;
            end else scan_in = scan_ff + 1'b1;
         end
         S_DEL: begin
            // queue update uses scan results
            if (count_ff == '0) q_in = '0;
            else if (k_ff == count_ff) q_in = tlast_ff ? '0 : q_ff;
            else if (r_ff == '0) q_in = ({1'b0, q_ff} >= k_ff) ? q_ff + 1'b1 : q_ff;
            else if (r_ff == 1 && k_ff == '0)
               q_in = (q_ff == '0) ? ((count_ff > 1) ? IW'(1) : '0) : q_ff;
            else q_in = (k_ff + r_ff < count_ff) ? IW'(k_ff + 1'b1) : '0;
            if (r_ff == '0) state_in = S_OPEN;
            else if (sh_ff + 1'b1 >= r_ff) begin
               count_in = count_ff - r_ff + 1'b1;
               state_in = S_LOAD;
            end else sh_in = sh_ff + 1'b1;
         end
         S_OPEN: begin
            count_in = count_ff + 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if ({1'b0, q_ff} >= count_ff) q_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the input while busy or while a result waits under stall
   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) rpos_ff <= req_position;
      e_ff <= e_in; scan_ff <= scan_in; k_ff <= k_in; r_ff <= r_in; sh_ff <= sh_in;
      on_ff <= on_in; off_ff <= off_in; drop_ff <= drop_in; nout_ff <= nout_in;
      pstart_ff <= pstart_in; pnote_ff <= pnote_in;
      if (reset) begin
         state_ff <= S_IDLE; steps_ff <= 7'd16; pvalid_ff <= 1'b0;
         count_ff <= '0; q_ff <= '0; rv_ff <= 1'b0; kfound_ff <= 1'b0;
         rdone_ff <= 1'b0; tlast_ff <= 1'b0;
      end else begin
         state_ff <= state_in; steps_ff <= steps_in; pvalid_ff <= pvalid_in;
         count_ff <= count_in; rv_ff <= rv_in; kfound_ff <= kfound_in;
         rdone_ff <= rdone_in; tlast_ff <= tlast_in;
         if (!(state_ff == S_DEL && sh_ff != '0)) q_ff <= q_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_note_on = on_ff;
   assign rsp_note_off = off_ff;
   assign rsp_note_out = nout_ff;
   assign rsp_dropped = drop_ff;

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("busy without stall");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EVENTS)) else $error("event count overflow");
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !(on_ff && off_ff)) else $error("on and off together");
endmodule
